// File: rtl/wdm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdm_pkg - shared types and constants
// Field widths of the marker detector channels and the request record that
// travels from the front end through the queue to the back end.
// ----------------------------------------------------------------------------
package wdm_pkg;

    localparam int SYM_W       = 5;
    localparam int POS_W       = 32;
    localparam int CFG_W       = 5;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_W-1:0] WIN_LEN_RESET = 5'd14;

    // One classified request: symbol already clamped into the alphabet.
    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic             first;
        logic             last;
    } t_op;

endpackage

// File: rtl/wdm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdm_if - symbol and result channels
// Valid/ready channels carrying symbol requests in and marker results out.
// ----------------------------------------------------------------------------
interface wdm_sym_if import wdm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] symbol;
    logic             first;
    logic             last;

    modport source (output valid, symbol, first, last, input ready);
    modport sink   (input valid, symbol, first, last, output ready);
endinterface

interface wdm_res_if import wdm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             found;
    logic [POS_W-1:0] position;

    modport source (output valid, found, position, input ready);
    modport sink   (input valid, found, position, output ready);
endinterface

// File: rtl/wdm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdm_front - request intake and classification
// Takes symbol requests while the queue has room and clamps the symbol into
// the alphabet before it is queued.
// ----------------------------------------------------------------------------
module wdm_front import wdm_pkg::*; #(
    parameter int ALPHABET = 26
) (
    wdm_sym_if.sink    i_sym,
    input  logic       i_q_full,
    output logic       o_q_push,
    output t_op        o_q_op
);

    // Letters beyond the alphabet fold onto its last letter.
    always_comb begin
        o_q_op.first = i_sym.first;
        o_q_op.last  = i_sym.last;
        if (32'(i_sym.symbol) >= ALPHABET) begin
            o_q_op.sym = SYM_W'(ALPHABET - 1);
        end else begin
            o_q_op.sym = i_sym.symbol;
        end
    end

    assign i_sym.ready = !i_q_full;
    assign o_q_push    = i_sym.valid && !i_q_full;

endmodule

// File: rtl/wdm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdm_queue - request queue between front and back end
// A small first-in first-out store so that intake and state update can stall
// independently of each other.
// ----------------------------------------------------------------------------
module wdm_queue import wdm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    output logic o_full,
    output logic o_valid,
    input  logic i_ready,
    output t_op  o_op
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_op              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_mem[r_rd_ptr];
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

endmodule

// File: rtl/wdm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdm_back - window state update and result register
// Keeps the symbol ring, per-letter counters and distinct count, applies one
// request per cycle unless a result waits, and registers the marker result.
// ----------------------------------------------------------------------------
module wdm_back import wdm_pkg::*; #(
    parameter int WINDOW_MAX = 16,
    parameter int ALPHABET   = 26
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [CFG_W-1:0] i_cfg_wr_data,
    input  logic             i_q_valid,
    output logic             o_q_ready,
    input  t_op              i_q_op,
    wdm_res_if.source        o_res
);

    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int IDX_W = $clog2(WINDOW_MAX);

    logic [SYM_W-1:0] r_ring [WINDOW_MAX];
    logic [CNT_W-1:0] r_cnt  [ALPHABET];
    logic [CNT_W-1:0] cur_cnt [ALPHABET];
    logic [CNT_W-1:0] n_cnt  [ALPHABET];
    logic [ALPHABET-1:0] gained, lost;

    logic [CFG_W-1:0] r_win_len;
    logic [IDX_W-1:0] r_idx, cur_idx, n_idx;
    logic [CNT_W-1:0] r_dist, cur_dist, n_dist;
    logic [POS_W-1:0] r_seen, cur_seen, n_seen;
    logic             r_done, cur_done;

    logic [CNT_W-1:0] eff_len;
    logic [CNT_W:0]   ev_pos;
    logic [IDX_W-1:0] ev_addr;
    logic [SYM_W-1:0] old_sym;
    logic             evict, hit, ended, pop;

    logic             r_out_valid;
    logic             r_out_found;
    logic [POS_W-1:0] r_out_pos;

    assign o_q_ready = !r_out_valid || o_res.ready;
    assign pop       = i_q_valid && o_q_ready;

    // Zero acts as one, anything above the ring size as the ring size.
    always_comb begin
        if (r_win_len == '0) begin
            eff_len = CNT_W'(1);
        end else if (32'(r_win_len) > WINDOW_MAX) begin
            eff_len = CNT_W'(WINDOW_MAX);
        end else begin
            eff_len = CNT_W'(r_win_len);
        end
    end

    // A first request sees the cleared stream state.
    always_comb begin
        cur_idx  = i_q_op.first ? '0 : r_idx;
        cur_dist = i_q_op.first ? '0 : r_dist;
        cur_seen = i_q_op.first ? '0 : r_seen;
        cur_done = i_q_op.first ? 1'b0 : r_done;
        for (int i = 0; i < ALPHABET; i++) begin
            cur_cnt[i] = i_q_op.first ? '0 : r_cnt[i];
        end
    end

    // Slot of the symbol leaving the window, len places behind the write slot.
    always_comb begin
        evict = (cur_seen >= POS_W'(eff_len));
        if ((CNT_W + 1)'(cur_idx) >= (CNT_W + 1)'(eff_len)) begin
            ev_pos = (CNT_W + 1)'(cur_idx) - (CNT_W + 1)'(eff_len);
        end else begin
            ev_pos = (CNT_W + 1)'(cur_idx) + (CNT_W + 1)'(WINDOW_MAX)
                   - (CNT_W + 1)'(eff_len);
        end
        ev_addr = ev_pos[IDX_W-1:0];
        old_sym = r_ring[ev_addr];
    end

    // Each letter counter updates itself and reports whether it appeared in
    // or vanished from the window; at most one letter does either.
    always_comb begin
        logic dec, inc;
        dec = 1'b0;
        inc = 1'b0;
        for (int i = 0; i < ALPHABET; i++) begin
            dec = evict && (32'(old_sym) == i) && (cur_cnt[i] != '0);
            inc = (32'(i_q_op.sym) == i);
            n_cnt[i]  = cur_cnt[i] - CNT_W'(dec) + CNT_W'(inc);
            gained[i] = (cur_cnt[i] == '0) && (n_cnt[i] != '0);
            lost[i]   = (cur_cnt[i] != '0) && (n_cnt[i] == '0);
        end
    end

    always_comb begin
        n_dist = cur_dist + CNT_W'(|gained) - CNT_W'(|lost);
        n_seen = (cur_seen == '1) ? cur_seen : cur_seen + 1'b1;
        n_idx  = (cur_idx == IDX_W'(WINDOW_MAX - 1)) ? '0 : cur_idx + 1'b1;
        hit    = !cur_done && (n_seen >= POS_W'(eff_len)) && (n_dist == eff_len);
        ended  = !cur_done && !hit && i_q_op.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_len <= WIN_LEN_RESET;
            r_idx     <= '0;
            r_dist    <= '0;
            r_seen    <= '0;
            r_done    <= 1'b0;
            for (int i = 0; i < ALPHABET; i++) begin
                r_cnt[i] <= '0;
            end
        end else if (i_cfg_wr_en) begin
            r_win_len <= i_cfg_wr_data;
            r_idx     <= '0;
            r_dist    <= '0;
            r_seen    <= '0;
            r_done    <= 1'b0;
            for (int i = 0; i < ALPHABET; i++) begin
                r_cnt[i] <= '0;
            end
        end else if (pop) begin
            r_idx  <= n_idx;
            r_dist <= n_dist;
            r_seen <= n_seen;
            r_done <= cur_done || hit || ended;
            for (int i = 0; i < ALPHABET; i++) begin
                r_cnt[i] <= n_cnt[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_ring[cur_idx] <= i_q_op.sym;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pop && (hit || ended)) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && (hit || ended)) begin
            r_out_found <= hit;
            r_out_pos   <= hit ? n_seen : '0;
        end
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.found    = r_out_found;
    assign o_res.position = r_out_pos;

endmodule

// File: rtl/window_distinct_marker_detector_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_distinct_marker_detector_core - sliding window marker detector
// Finds the first place in a symbol stream where the last window_len symbols
// are all different and reports its 1-based position, or reports that the
// stream ended without such a marker.
//
//   channel   dir  handshake        payload
//   i_sym     in   valid / ready    symbol[4:0], first, last
//   o_res     out  valid / ready    found, position[31:0]
//   i_cfg     in   wr_en only       wr_data[4:0] = window length
//
// Throughput is one symbol request per clock while the result side is not
// stalled. A taken request passes the request queue and the state update
// before its result is held in the output register. The state update loop
// (letter counters and distinct count) sets that rate.
// Reset is synchronous and active low; it restores a window length of 14 and
// an empty stream. The queue keeps intake running for two requests while the
// result side is stalled.
// ----------------------------------------------------------------------------
module window_distinct_marker_detector_core import wdm_pkg::*; #(
    parameter int WINDOW_MAX = 16,
    parameter int ALPHABET   = 26
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [CFG_W-1:0] i_cfg_wr_data,
    wdm_sym_if.sink          i_sym,
    wdm_res_if.source        o_res
);

    // Front end to queue.
    logic q_push;
    logic q_full;
    t_op  q_in_op;

    // Queue to back end.
    logic q_valid;
    logic q_ready;
    t_op  q_out_op;

    // The front end only clamps the symbol and pushes while there is room.
    wdm_front #(
        .ALPHABET (ALPHABET)
    ) u_front (
        .i_sym    (i_sym),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_op   (q_in_op)
    );

    // Decouples intake from the state update so either side can stall.
    wdm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (q_in_op),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_op    (q_out_op)
    );

    // The back end owns all stream state and the result register. A window
    // length write also clears the stream, so it lands there as well.
    wdm_back #(
        .WINDOW_MAX (WINDOW_MAX),
        .ALPHABET   (ALPHABET)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_q_valid     (q_valid),
        .o_q_ready     (q_ready),
        .i_q_op        (q_out_op),
        .o_res         (o_res)
    );

`ifndef SYNTH
    // The front end never pushes into a full queue.
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("request pushed into a full queue");

    // A new result can only follow a request taken by the back end.
    a_result_from_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res.valid) |-> $past(q_valid && q_ready))
        else $error("result appeared without a request");

    // Reset empties the result register.
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("result valid after reset");
`endif

endmodule
